// ===== src/hii_pkg.sv =====
// ============================================================================
// hii_pkg : shared types and constants for the HII package list parser
// Result codes and the record passed from the parser front to the output back.
// ============================================================================
`default_nettype none
package hii_pkg;
    localparam logic [1:0] KIND_GLYPH  = 2'd0;
    localparam logic [1:0] KIND_LAYOUT = 2'd1;
    localparam logic [1:0] KIND_ACCEPT = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_WIDE      = 4'd1;
    localparam logic [3:0] ST_GLYPH_OVR = 4'd2;
    localparam logic [3:0] ST_KBD_SHORT = 4'd3;
    localparam logic [3:0] ST_HDR_OVR   = 4'd4;
    localparam logic [3:0] ST_REC_SHORT = 4'd5;
    localparam logic [3:0] ST_REC_OVR   = 4'd6;
    localparam logic [3:0] ST_LEN_MIS   = 4'd7;
    localparam logic [3:0] ST_PKG_SHORT = 4'd8;
    localparam logic [3:0] ST_TRUNC     = 4'd9;

    localparam logic [7:0]  FONT_TYPE  = 8'h07;
    localparam logic [7:0]  KEYS_TYPE  = 8'h09;
    localparam logic [15:0] MIN_RECORD = 16'd23;
    localparam logic [23:0] KEYS_HDR   = 24'd6;
    localparam logic [23:0] FONT_HDR   = 24'd8;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  status;
        logic [15:0] char_code;
        logic [4:0]  glyph_row;
        logic [7:0]  row_pixels;
        logic [31:0] record_offset;
        logic [15:0] record_size;
        logic        final_res;
    } t_result;
endpackage
`default_nettype wire

// ===== src/hii_front.sv =====
// ============================================================================
// hii_front : byte parser
// Walks the list one byte a cycle while i_step is high and produces up to two results per byte.
// ============================================================================
`default_nettype none
module hii_front #(
    parameter int LIST_HEADER_BYTES = 20,
    parameter int GLYPH_ROWS        = 19
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic [7:0]       i_data_byte,
    input  wire logic             i_last_byte,
    output hii_pkg::t_result      o_res0,
    output hii_pkg::t_result      o_res1,
    output logic [1:0]            o_count
);
    localparam logic [3:0] PH_LIST  = 4'd0;
    localparam logic [3:0] PH_PKG   = 4'd1;
    localparam logic [3:0] PH_FONT  = 4'd2;
    localparam logic [3:0] PH_GLYPH = 4'd3;
    localparam logic [3:0] PH_SKIP  = 4'd4;
    localparam logic [3:0] PH_COUNT = 4'd5;
    localparam logic [3:0] PH_RSIZE = 4'd6;
    localparam logic [3:0] PH_RBODY = 4'd7;
    localparam int GLYPH_LEN = GLYPH_ROWS + 3;
    localparam logic [31:0] HDR_BYTES = 32'(LIST_HEADER_BYTES);
    localparam logic [5:0]  GLYPH_LAST = 6'(GLYPH_LEN - 1);
    localparam logic [5:0]  GLYPH_LEN_W = 6'(GLYPH_LEN);

    logic [31:0] r_list_pos, n_list_pos;
    logic [23:0] r_pkg_pos, n_pkg_pos;
    logic [23:0] r_pkg_size, n_pkg_size;
    logic [3:0]  r_phase, n_phase;
    logic [15:0] r_glyphs, n_glyphs;
    logic [15:0] r_glyph_num, n_glyph_num;
    logic [5:0]  r_glyph_byte, n_glyph_byte;
    logic [15:0] r_code, n_code;
    logic [15:0] r_layouts, n_layouts;
    logic [15:0] r_layout_num, n_layout_num;
    logic [23:0] r_next_rec, n_next_rec;
    logic [7:0]  r_low, n_low;
    logic        r_err, n_err;

    logic [3:0]  ph, err;
    logic [23:0] pos;
    logic [15:0] rsz;
    logic [24:0] rec_end;
    logic [24:0] font_need;
    logic [15:0] wide;
    hii_pkg::t_result res0, res1;
    logic [1:0] cnt;

    always_comb begin
        n_list_pos = r_list_pos; n_pkg_pos = r_pkg_pos; n_pkg_size = r_pkg_size;
        n_phase = r_phase; n_glyphs = r_glyphs; n_glyph_num = r_glyph_num;
        n_glyph_byte = r_glyph_byte; n_code = r_code; n_layouts = r_layouts;
        n_layout_num = r_layout_num; n_next_rec = r_next_rec; n_low = r_low;
        n_err = r_err;
        err = hii_pkg::ST_OK;
        res0 = '0; res1 = '0; cnt = 2'd0;
        pos = r_pkg_pos;
        rsz = {i_data_byte, r_low};
        rec_end = {1'b0, r_next_rec} + {9'd0, rsz};
        font_need = 25'(r_glyphs) * 25'(GLYPH_LEN_W) + 25'(hii_pkg::FONT_HDR);
        wide = {i_data_byte, r_low};
        ph = r_phase;
        if (ph == PH_LIST && r_list_pos >= HDR_BYTES) ph = PH_PKG;
        n_phase = ph;
        if (r_err) begin
            if (i_last_byte) begin
                n_list_pos = '0; n_pkg_pos = '0; n_pkg_size = '0; n_phase = PH_LIST;
                n_glyphs = '0; n_glyph_num = '0; n_glyph_byte = '0; n_code = '0;
                n_layouts = '0; n_layout_num = '0; n_next_rec = '0; n_low = '0;
                n_err = 1'b0;
            end
        end else begin
            unique case (ph)
                PH_PKG: begin
                    if (pos < 24'd3) begin
                        case (pos[1:0])
                            2'd0: n_pkg_size[7:0] = i_data_byte;
                            2'd1: n_pkg_size[15:8] = i_data_byte;
                            default: n_pkg_size[23:16] = i_data_byte;
                        endcase
                    end else if (r_pkg_size < 24'd4) begin
                        err = hii_pkg::ST_PKG_SHORT;
                    end else if (i_data_byte == hii_pkg::FONT_TYPE) begin
                        if (r_pkg_size < hii_pkg::FONT_HDR) err = hii_pkg::ST_GLYPH_OVR;
                        else n_phase = PH_FONT;
                    end else if (i_data_byte == hii_pkg::KEYS_TYPE) begin
                        if (r_pkg_size < hii_pkg::KEYS_HDR) err = hii_pkg::ST_KBD_SHORT;
                        else n_phase = PH_COUNT;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
                PH_FONT: begin
                    if (pos == 24'd4) n_glyphs = {8'd0, i_data_byte};
                    else if (pos == 24'd5) n_glyphs = {i_data_byte, r_glyphs[7:0]};
                    else if (pos == 24'd6) n_low = i_data_byte;
                    else if (wide != 16'd0) err = hii_pkg::ST_WIDE;
                    else if (font_need > {1'b0, r_pkg_size}) err = hii_pkg::ST_GLYPH_OVR;
                    else if (r_glyphs == 16'd0) n_phase = PH_SKIP;
                    else begin
                        n_phase = PH_GLYPH; n_glyph_byte = '0; n_glyph_num = '0;
                    end
                end
                PH_GLYPH: begin
                    if (r_glyph_byte == 6'd0) n_code = {8'd0, i_data_byte};
                    else if (r_glyph_byte == 6'd1) n_code = {i_data_byte, r_code[7:0]};
                    else if (r_glyph_byte >= 6'd3) begin
                        res0.kind = hii_pkg::KIND_GLYPH;
                        res0.char_code = r_code;
                        res0.glyph_row = 5'(r_glyph_byte - 6'd3);
                        res0.row_pixels = i_data_byte;
                        cnt = 2'd1;
                    end
                    if (r_glyph_byte >= GLYPH_LAST) begin
                        n_glyph_byte = '0;
                        n_glyph_num = r_glyph_num + 16'd1;
                        if (n_glyph_num >= r_glyphs) n_phase = PH_SKIP;
                    end else begin
                        n_glyph_byte = r_glyph_byte + 6'd1;
                    end
                end
                PH_COUNT: begin
                    if (pos == 24'd4) n_layouts = {8'd0, i_data_byte};
                    else begin
                        n_layouts = {i_data_byte, r_layouts[7:0]};
                        n_layout_num = '0;
                        n_next_rec = hii_pkg::KEYS_HDR;
                        if (n_layouts == 16'd0) begin
                            if (r_pkg_size != hii_pkg::KEYS_HDR) err = hii_pkg::ST_LEN_MIS;
                            else n_phase = PH_SKIP;
                        end else if (r_pkg_size < 24'd8) err = hii_pkg::ST_HDR_OVR;
                        else n_phase = PH_RSIZE;
                    end
                end
                PH_RSIZE: begin
                    if (pos == r_next_rec) n_low = i_data_byte;
                    else if (rsz < hii_pkg::MIN_RECORD) err = hii_pkg::ST_REC_SHORT;
                    else if (rec_end > {1'b0, r_pkg_size}) err = hii_pkg::ST_REC_OVR;
                    else begin
                        res0.kind = hii_pkg::KIND_LAYOUT;
                        res0.record_offset = r_list_pos - 32'd1;
                        res0.record_size = rsz;
                        cnt = 2'd1;
                        n_next_rec = rec_end[23:0];
                        n_layout_num = r_layout_num + 16'd1;
                        if (n_layout_num >= r_layouts) begin
                            if (rec_end != {1'b0, r_pkg_size}) err = hii_pkg::ST_LEN_MIS;
                            n_phase = PH_SKIP;
                        end else begin
                            if (rec_end + 25'd2 > {1'b0, r_pkg_size})
                                err = hii_pkg::ST_HDR_OVR;
                            n_phase = PH_RBODY;
                        end
                    end
                end
                PH_RBODY: begin
                    if ({1'b0, pos} + 25'd1 >= {1'b0, r_next_rec}) n_phase = PH_RSIZE;
                end
                default: ;
            endcase
            n_list_pos = r_list_pos + 32'd1;
            if (err != hii_pkg::ST_OK) begin
                if (cnt == 2'd1) begin
                    res1.kind = hii_pkg::KIND_ERROR; res1.status = err; cnt = 2'd2;
                end else begin
                    res0.kind = hii_pkg::KIND_ERROR; res0.status = err; cnt = 2'd1;
                end
                n_err = 1'b1;
            end else begin
                if (n_phase != PH_LIST) begin
                    if (pos >= 24'd3 && {1'b0, pos} + 25'd1 >= {1'b0, r_pkg_size}) begin
                        n_phase = PH_PKG; n_pkg_pos = '0; n_pkg_size = '0;
                    end else begin
                        n_pkg_pos = pos + 24'd1;
                    end
                end
                if (i_last_byte) begin
                    if (cnt == 2'd1) begin
                        res1.kind = hii_pkg::KIND_ERROR; res1.status = hii_pkg::ST_TRUNC;
                        if (n_phase == PH_LIST || (n_phase == PH_PKG && n_pkg_pos == '0))
                            begin res1.kind = hii_pkg::KIND_ACCEPT; res1.status = hii_pkg::ST_OK; end
                        cnt = 2'd2;
                    end else begin
                        res0.kind = hii_pkg::KIND_ERROR; res0.status = hii_pkg::ST_TRUNC;
                        if (n_phase == PH_LIST || (n_phase == PH_PKG && n_pkg_pos == '0))
                            begin res0.kind = hii_pkg::KIND_ACCEPT; res0.status = hii_pkg::ST_OK; end
                        cnt = 2'd1;
                    end
                end
            end
            if (i_last_byte) begin
                n_list_pos = '0; n_pkg_pos = '0; n_pkg_size = '0; n_phase = PH_LIST;
                n_glyphs = '0; n_glyph_num = '0; n_glyph_byte = '0; n_code = '0;
                n_layouts = '0; n_layout_num = '0; n_next_rec = '0; n_low = '0;
                n_err = 1'b0;
            end
        end
        if (cnt == 2'd2) res1.final_res = 1'b1;
        else if (cnt == 2'd1) res0.final_res = 1'b1;
    end

    assign o_res0 = res0;
    assign o_res1 = res1;
    assign o_count = i_step ? cnt : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_pos <= '0; r_pkg_pos <= '0; r_pkg_size <= '0; r_phase <= PH_LIST;
            r_glyphs <= '0; r_glyph_num <= '0; r_glyph_byte <= '0; r_code <= '0;
            r_layouts <= '0; r_layout_num <= '0; r_next_rec <= '0; r_low <= '0;
            r_err <= 1'b0;
        end else if (i_step) begin
            r_list_pos <= n_list_pos; r_pkg_pos <= n_pkg_pos; r_pkg_size <= n_pkg_size;
            r_phase <= n_phase; r_glyphs <= n_glyphs; r_glyph_num <= n_glyph_num;
            r_glyph_byte <= n_glyph_byte; r_code <= n_code; r_layouts <= n_layouts;
            r_layout_num <= n_layout_num; r_next_rec <= n_next_rec; r_low <= n_low;
            r_err <= n_err;
        end
    end
endmodule
`default_nettype wire

// ===== src/hii_queue.sv =====
// ============================================================================
// hii_queue : result queue
// Four-entry FIFO taking up to two results a cycle, giving one a cycle while i_pop is high.
// ============================================================================
`default_nettype none
module hii_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  hii_pkg::t_result      i_res0,
    input  hii_pkg::t_result      i_res1,
    input  wire logic [1:0]       i_count,
    input  wire logic             i_pop,
    output hii_pkg::t_result      o_head,
    output logic                  o_valid,
    output logic                  o_room
);
    hii_pkg::t_result r_mem [4];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_fill, n_fill;
    logic       pop;

    assign pop = i_pop && (r_fill != 3'd0);
    assign o_head = r_mem[r_rd];
    assign o_valid = r_fill != 3'd0;
    assign o_room = r_fill <= 3'd2;
    assign n_fill = r_fill + {1'b0, i_count} - {2'd0, pop};

    always_ff @(posedge i_clk) begin
        if (i_count != 2'd0) r_mem[r_wr] <= i_res0;
        if (i_count == 2'd2) r_mem[r_wr + 2'd1] <= i_res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0; r_rd <= '0; r_fill <= '0;
        end else begin
            r_wr <= r_wr + i_count;
            r_rd <= r_rd + {1'b0, pop};
            r_fill <= n_fill;
        end
    end
endmodule
`default_nettype wire

// ===== src/hii_package_list_parser.sv =====
// ============================================================================
// hii_package_list_parser : HII font and keyboard package list parser
// Channel   | dir | beat
// input     | in  | i_data_byte, i_last_byte    (i_valid / o_stall)
// result    | out | o_kind .. o_final_res       (o_valid / i_stall)
// One byte a cycle when not stalled; a byte yields at most two results into a four-entry queue.
// The input stalls only when the queue has fewer than two free entries.
// Results leave one a cycle while i_stall is low.
// Synchronous active-low reset returns the parser to the list header.
// ============================================================================
`default_nettype none
module hii_package_list_parser #(
    parameter int LIST_HEADER_BYTES = 20,
    parameter int GLYPH_ROWS        = 19
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_kind,
    output logic [3:0]       o_status,
    output logic [15:0]      o_char_code,
    output logic [4:0]       o_glyph_row,
    output logic [7:0]       o_row_pixels,
    output logic [31:0]      o_record_offset,
    output logic [15:0]      o_record_size,
    output logic             o_final_res
);
    hii_pkg::t_result res0, res1, head;
    logic [1:0] cnt;
    logic room, step;

    assign step = i_valid && room;
    assign o_stall = !room;

    hii_front #(.LIST_HEADER_BYTES(LIST_HEADER_BYTES), .GLYPH_ROWS(GLYPH_ROWS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(step),
        .i_data_byte(i_data_byte), .i_last_byte(i_last_byte),
        .o_res0(res0), .o_res1(res1), .o_count(cnt)
    );

    hii_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_res0(res0), .i_res1(res1),
        .i_count(cnt), .i_pop(!i_stall), .o_head(head), .o_valid(o_valid),
        .o_room(room)
    );

    assign o_kind = head.kind;
    assign o_status = head.status;
    assign o_char_code = head.char_code;
    assign o_glyph_row = head.glyph_row;
    assign o_row_pixels = head.row_pixels;
    assign o_record_offset = head.record_offset;
    assign o_record_size = head.record_size;
    assign o_final_res = head.final_res;
endmodule
`default_nettype wire

// ===== bench/tb_hii_package_list_parser.sv =====
// ============================================================================
// tb_hii_package_list_parser : self-checking bench for the HII list parser
// Streams package lists byte by byte (fonts, keyboard layouts, other types,
// broken and truncated lists) with random idling on both sides, predicts
// every result and compares each output beat field by field, in order.
// ============================================================================
`timescale 1ns / 100ps
`default_nettype none
module tb_hii_package_list_parser;
    localparam int HDR_BYTES = 20;
    localparam int ROWS      = 19;
    localparam int GLYPH_LEN = 3 + ROWS;

    typedef enum logic [3:0] {
        P_LIST, P_PKG, P_FONT, P_GLYPH, P_SKIP, P_COUNT, P_RSIZE, P_RBODY
    } t_phase;

    logic        i_clk, i_rst_n, i_valid, i_stall, i_last_byte;
    logic [7:0]  i_data_byte;
    logic        o_stall, o_valid, o_final_res;
    logic [1:0]  o_kind;
    logic [3:0]  o_status;
    logic [15:0] o_char_code, o_record_size;
    logic [4:0]  o_glyph_row;
    logic [7:0]  o_row_pixels;
    logic [31:0] o_record_offset;

    hii_package_list_parser dut (.*);

    // parser shadow state
    logic [31:0] list_pos;
    logic [23:0] pkg_pos, pkg_len, rec_start;
    t_phase      phase;
    logic [15:0] n_glyphs, glyph_idx, code, n_layouts, layout_idx;
    logic [4:0]  gbyte;
    logic [7:0]  lo_hold;
    logic        errored;

    hii_pkg::t_result expected_results[$];
    logic [8:0] list_bytes[$];
    int fails = 0;
    bit idle_on = 1'b1;

    function automatic hii_pkg::t_result mk(logic [1:0] k, logic [3:0] s);
        hii_pkg::t_result r;
        r = '0;
        r.kind = k;
        r.status = s;
        return r;
    endfunction

    task automatic clear_parser();
        list_pos = 0; pkg_pos = 0; pkg_len = 0; phase = P_LIST;
        n_glyphs = 0; glyph_idx = 0; gbyte = 0; code = 0; n_layouts = 0;
        layout_idx = 0; rec_start = 0; lo_hold = 0; errored = 0;
    endtask

    task automatic predict_byte(logic [7:0] b, logic last);
        hii_pkg::t_result r, q[$];
        logic [3:0]  err;
        logic [23:0] pos;
        logic [31:0] sz;
        err = hii_pkg::ST_OK;
        if (errored) begin
            if (last) clear_parser();
            return;
        end
        if (phase == P_LIST && list_pos >= HDR_BYTES) phase = P_PKG;
        pos = pkg_pos;
        case (phase)
            P_PKG: begin
                if (pos < 3) pkg_len = pkg_len | (24'(b) << (8 * pos));
                else if (pkg_len < 4) err = hii_pkg::ST_PKG_SHORT;
                else if (b == hii_pkg::FONT_TYPE) begin
                    if (pkg_len < hii_pkg::FONT_HDR) err = hii_pkg::ST_GLYPH_OVR;
                    else phase = P_FONT;
                end else if (b == hii_pkg::KEYS_TYPE) begin
                    if (pkg_len < hii_pkg::KEYS_HDR) err = hii_pkg::ST_KBD_SHORT;
                    else phase = P_COUNT;
                end else phase = P_SKIP;
            end
            P_FONT: begin
                if (pos == 4) n_glyphs = 16'(b);
                else if (pos == 5) n_glyphs[15:8] = b;
                else if (pos == 6) lo_hold = b;
                else if ({b, lo_hold} != 0) err = hii_pkg::ST_WIDE;
                else if (32'(hii_pkg::FONT_HDR) + 32'(n_glyphs) * GLYPH_LEN > 32'(pkg_len))
                    err = hii_pkg::ST_GLYPH_OVR;
                else if (n_glyphs == 0) phase = P_SKIP;
                else begin
                    phase = P_GLYPH; gbyte = 0; glyph_idx = 0;
                end
            end
            P_GLYPH: begin
                if (gbyte == 0) code = 16'(b);
                else if (gbyte == 1) code[15:8] = b;
                else if (gbyte >= 3) begin
                    r = mk(hii_pkg::KIND_GLYPH, hii_pkg::ST_OK);
                    r.char_code = code; r.glyph_row = gbyte - 5'd3; r.row_pixels = b;
                    q.push_back(r);
                end
                if (int'(gbyte) + 1 >= GLYPH_LEN) begin
                    gbyte = 0; glyph_idx++;
                    if (glyph_idx >= n_glyphs) phase = P_SKIP;
                end else gbyte++;
            end
            P_COUNT: begin
                if (pos == 4) n_layouts = 16'(b);
                else begin
                    n_layouts[15:8] = b; layout_idx = 0; rec_start = hii_pkg::KEYS_HDR;
                    if (n_layouts == 0) begin
                        if (pkg_len != hii_pkg::KEYS_HDR) err = hii_pkg::ST_LEN_MIS;
                        else phase = P_SKIP;
                    end else if (hii_pkg::KEYS_HDR + 2 > pkg_len) err = hii_pkg::ST_HDR_OVR;
                    else phase = P_RSIZE;
                end
            end
            P_RSIZE: begin
                if (pos == rec_start) lo_hold = b;
                else begin
                    sz = {16'd0, b, lo_hold};
                    if (sz < hii_pkg::MIN_RECORD) err = hii_pkg::ST_REC_SHORT;
                    else if (32'(rec_start) + sz > 32'(pkg_len)) err = hii_pkg::ST_REC_OVR;
                    else begin
                        r = mk(hii_pkg::KIND_LAYOUT, hii_pkg::ST_OK);
                        r.record_offset = list_pos - 1; r.record_size = sz[15:0];
                        q.push_back(r);
                        rec_start = rec_start + sz[23:0];
                        layout_idx++;
                        if (layout_idx >= n_layouts) begin
                            if (rec_start != pkg_len) err = hii_pkg::ST_LEN_MIS;
                            phase = P_SKIP;
                        end else begin
                            if (32'(rec_start) + 2 > 32'(pkg_len)) err = hii_pkg::ST_HDR_OVR;
                            phase = P_RBODY;
                        end
                    end
                end
            end
            P_RBODY: if (32'(pos) + 1 >= 32'(rec_start)) phase = P_RSIZE;
            default: ;
        endcase
        list_pos++;
        if (err != hii_pkg::ST_OK) begin
            q.push_back(mk(hii_pkg::KIND_ERROR, err));
            if (last) clear_parser(); else errored = 1;
        end else begin
            if (phase != P_LIST) begin
                if (pos >= 3 && 32'(pos) + 1 >= 32'(pkg_len)) begin
                    phase = P_PKG; pkg_pos = 0; pkg_len = 0;
                end else pkg_pos = pos + 1;
            end
            if (last) begin
                if (phase == P_LIST || (phase == P_PKG && pkg_pos == 0))
                    q.push_back(mk(hii_pkg::KIND_ACCEPT, hii_pkg::ST_OK));
                else q.push_back(mk(hii_pkg::KIND_ERROR, hii_pkg::ST_TRUNC));
                clear_parser();
            end
        end
        if (q.size() > 0) q[q.size() - 1].final_res = 1'b1;
        foreach (q[i]) expected_results.push_back(q[i]);
    endtask

    // ---------------- list builders ----------------
    task automatic put_le(int v, int n);
        for (int i = 0; i < n; i++) list_bytes.push_back({1'b0, 8'(v >> (8 * i))});
    endtask

    task automatic put_hdr();
        for (int i = 0; i < HDR_BYTES; i++) list_bytes.push_back({1'b0, 8'($urandom)});
    endtask

    task automatic put_font(int ng, bit wide);
        int len;
        len = 8 + ng * GLYPH_LEN;
        put_le(len, 3); put_le(hii_pkg::FONT_TYPE, 1);
        put_le(ng, 2); put_le(wide ? $urandom_range(1, 65535) : 0, 2);
        for (int g = 0; g < ng; g++) begin
            put_le($urandom, 2); put_le($urandom, 1);
            for (int k = 0; k < ROWS; k++) put_le($urandom, 1);
        end
    endtask

    task automatic put_keys(int nl);
        int sizes[$];
        int len;
        len = 6;
        for (int i = 0; i < nl; i++) begin
            sizes.push_back($urandom_range(23, 40));
            len += sizes[i];
        end
        put_le(len, 3); put_le(hii_pkg::KEYS_TYPE, 1); put_le(nl, 2);
        foreach (sizes[i]) begin
            put_le(sizes[i], 2);
            for (int k = 2; k < sizes[i]; k++) put_le($urandom, 1);
        end
    endtask

    task automatic put_other();
        int len;
        len = $urandom_range(4, 12);
        put_le(len, 3);
        put_le($urandom_range(0, 255), 1);
        for (int k = 4; k < len; k++) put_le($urandom, 1);
    endtask

    task automatic end_list();
        if (list_bytes.size() == 0) list_bytes.push_back(9'h0);
        list_bytes[list_bytes.size() - 1][8] = 1'b1;
    endtask

    task automatic corrupt();
        int i;
        i = $urandom_range(HDR_BYTES, list_bytes.size() - 1);
        if ($urandom_range(0, 1)) list_bytes[i][7:0] = $urandom;
        else list_bytes = list_bytes[0:i];
    endtask

    // ---------------- clock, reset, watchdog ----------------
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("[hii_package_list_parser] ERROR");
        $finish;
    end

    // ---------------- result side ----------------
    always @(posedge i_clk) begin
        hii_pkg::t_result got, exp_r;
        if (i_rst_n) begin
            i_stall <= idle_on && ($urandom_range(0, 99) < 31);
            if (o_valid && !i_stall) begin
                got = '{o_kind, o_status, o_char_code, o_glyph_row, o_row_pixels,
                        o_record_offset, o_record_size, o_final_res};
                if (expected_results.size() == 0) begin
                    $display("%0t unexpected result: expected none actual %h", $time, got);
                    fails++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        $display("%0t mismatch: expected %p actual %p", $time, exp_r, got);
                        fails++;
                    end
                end
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic send_byte(logic [7:0] b, logic last);
        while (idle_on && $urandom_range(0, 99) < 31) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1; i_data_byte <= b; i_last_byte <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_byte(b, last);
    endtask

    task automatic send_list();
        foreach (list_bytes[i]) send_byte(list_bytes[i][7:0], list_bytes[i][8]);
        list_bytes.delete();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // directed packages: length (24 bit), type, expected result on the type byte
    typedef struct { int len; logic [7:0] ptype; logic [1:0] k; logic [3:0] s; } t_row;
    t_row dir_rows[6] = '{
        '{3, 8'hFF, hii_pkg::KIND_ERROR, hii_pkg::ST_PKG_SHORT},
        '{0, 8'h00, hii_pkg::KIND_ERROR, hii_pkg::ST_PKG_SHORT},
        '{7, hii_pkg::FONT_TYPE, hii_pkg::KIND_ERROR, hii_pkg::ST_GLYPH_OVR},
        '{5, hii_pkg::KEYS_TYPE, hii_pkg::KIND_ERROR, hii_pkg::ST_KBD_SHORT},
        '{24'hFFFFFF, 8'h07 ^ 8'h07, hii_pkg::KIND_ERROR, hii_pkg::ST_TRUNC},
        '{4, 8'h80, hii_pkg::KIND_ACCEPT, hii_pkg::ST_OK}
    };

    initial begin
        int r;
        i_rst_n = 0; i_valid = 0; i_stall = 0; i_data_byte = 0; i_last_byte = 0;
        clear_parser();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: short lists and header-level special cases
        list_bytes.push_back(9'h1FF); send_list();
        put_hdr(); end_list(); send_list();
        foreach (dir_rows[i]) begin
            while (expected_results.size() > 0) @(posedge i_clk);
            put_hdr(); put_le(dir_rows[i].len, 3); put_le(dir_rows[i].ptype, 1);
            end_list(); send_list();
            if (expected_results.size() > 0 &&
                (expected_results[0].kind !== dir_rows[i].k ||
                 expected_results[0].status !== dir_rows[i].s)) begin
                $display("%0t table row %0d: expected %0d/%0d predicted %0d/%0d", $time,
                         i, dir_rows[i].k, dir_rows[i].s,
                         expected_results[0].kind, expected_results[0].status);
                fails++;
            end
        end
        put_hdr(); put_font(1, 1); end_list(); send_list();
        put_hdr(); put_font(2, 0); put_keys(2); put_other(); end_list(); send_list();
        put_hdr(); put_keys(0); put_font(0, 0); end_list(); send_list();

        // random lists; first stretch without idling
        idle_on = 0;
        for (int n = 0; n < 5; n++) begin
            if (n == 2) idle_on = 1;
            put_hdr();
            r = $urandom_range(1, 3);
            for (int p = 0; p < r; p++)
                case ($urandom_range(0, 3))
                    0: put_font($urandom_range(0, 1), $urandom_range(0, 9) == 0);
                    1, 2: put_keys($urandom_range(0, 3));
                    default: put_other();
                endcase
            if ($urandom_range(0, 3) == 0) corrupt();
            end_list();
            send_list();
        end

        r = 0;
        while (expected_results.size() > 0 && r < 100_000) begin
            @(posedge i_clk); r++;
        end
        repeat (20) @(posedge i_clk);
        if (fails == 0 && expected_results.size() == 0)
            $display("[hii_package_list_parser] OK");
        else
            $display("[hii_package_list_parser] ERROR");
        $finish;
    end
endmodule
`default_nettype wire

// ===== hii_package_list_parser.f =====
src/hii_pkg.sv
src/hii_front.sv
src/hii_queue.sv
src/hii_package_list_parser.sv
bench/tb_hii_package_list_parser.sv
